FILE: rtl/hbv_pkg.sv
`default_nettype none

package hbv_pkg;

    localparam int CYCLE_WIDTH = 10;
    localparam int HB_CFG_WIDTH = 16;
    localparam int VB_CFG_WIDTH = 24;
    localparam int CFG_DATA_WIDTH = 24;

    localparam logic [HB_CFG_WIDTH-1:0] HBLANK_PERIOD_RST = 16'd2172;
    localparam logic [HB_CFG_WIDTH-1:0] HBLANK_DURATION_RST = 16'd390;
    localparam logic [VB_CFG_WIDTH-1:0] VBLANK_PERIOD_RST = 24'd564480;
    localparam logic [VB_CFG_WIDTH-1:0] VBLANK_DURATION_RST = 24'd50000;

    typedef enum logic [1:0] {
        REG_HBLANK_PERIOD = 2'd0,
        REG_HBLANK_DURATION = 2'd1,
        REG_VBLANK_PERIOD = 2'd2,
        REG_VBLANK_DURATION = 2'd3
    } hbv_reg_idx_t;

    typedef struct packed {
        logic [HB_CFG_WIDTH-1:0] hblank_period;
        logic [HB_CFG_WIDTH-1:0] hblank_duration;
        logic [VB_CFG_WIDTH-1:0] vblank_period;
        logic [VB_CFG_WIDTH-1:0] vblank_duration;
    } hbv_cfg_t;

    typedef struct packed {
        logic began;
        logic ended;
        logic level;
    } hbv_evt_t;

endpackage

`default_nettype wire

FILE: rtl/hbv_channels.sv
`default_nettype none

interface hbv_cycles_if import hbv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CYCLE_WIDTH-1:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink (input valid, input elapsed_cycles, output ready);
endinterface

interface hbv_event_if ();
    logic valid;
    logic ready;
    logic hblank_rise;
    logic hblank_fall;
    logic vblank_rise;
    logic vblank_fall;
    logic hblank_level;
    logic vblank_level;

    modport source (
        output valid, output hblank_rise, output hblank_fall, output vblank_rise,
        output vblank_fall, output hblank_level, output vblank_level, input ready
    );
    modport sink (
        input valid, input hblank_rise, input hblank_fall, input vblank_rise,
        input vblank_fall, input hblank_level, input vblank_level, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/hblank_vblank_event_generator_top.sv
// channel      dir   signals                                    request
// cycles_chan  sink  valid ready elapsed_cycles[9:0]            one cycle count
// event_chan   src   valid ready hblank_/vblank_ rise fall level one event set
// cfg port     sink  cfg_we cfg_index[1:0] cfg_wdata[23:0]      one register write
//
// one request per clock sustained while results are taken; an accepted request is held
// in the input register, and the generator update then carries it into the result register
// reset clears both generators, the pipeline valids, and loads default register values
// a stalled result holds the input register; ready drops only when both are full
// and the result is not taken
`default_nettype none

module hblank_vblank_event_generator_top
    import hbv_pkg::*;
#(
    parameter int LINE_COUNT_WIDTH = 16,
    parameter int FRAME_COUNT_WIDTH = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire hbv_reg_idx_t              cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    hbv_cycles_if.sink                     cycles_chan,
    hbv_event_if.source                    event_chan
);

    hbv_cfg_t cfg;
    hbv_evt_t h_evt;
    hbv_evt_t v_evt;

    logic                   in_valid_reg;
    logic [CYCLE_WIDTH-1:0] in_cycles_reg;
    logic                   out_valid_reg;
    hbv_evt_t               h_evt_reg;
    hbv_evt_t               v_evt_reg;
    logic                   advance;
    logic                   step;

    hbv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = !out_valid_reg || event_chan.ready;
    assign step = in_valid_reg && advance;
    assign cycles_chan.ready = !in_valid_reg || advance;

    hbv_blank_gen #(
        .COUNT_WIDTH (LINE_COUNT_WIDTH),
        .CFG_WIDTH   (HB_CFG_WIDTH)
    ) u_hgen (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cycles   (in_cycles_reg),
        .period   (cfg.hblank_period),
        .duration (cfg.hblank_duration),
        .evt      (h_evt)
    );

    hbv_blank_gen #(
        .COUNT_WIDTH (FRAME_COUNT_WIDTH),
        .CFG_WIDTH   (VB_CFG_WIDTH)
    ) u_vgen (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cycles   (in_cycles_reg),
        .period   (cfg.vblank_period),
        .duration (cfg.vblank_duration),
        .evt      (v_evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cycles_chan.ready)
            begin
                in_valid_reg <= cycles_chan.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cycles_chan.valid && cycles_chan.ready)
        begin
            in_cycles_reg <= cycles_chan.elapsed_cycles;
        end
        if (step)
        begin
            h_evt_reg <= h_evt;
            v_evt_reg <= v_evt;
        end
    end

    assign event_chan.valid = out_valid_reg;
    assign event_chan.hblank_rise = h_evt_reg.began;
    assign event_chan.hblank_fall = h_evt_reg.ended;
    assign event_chan.hblank_level = h_evt_reg.level;
    assign event_chan.vblank_rise = v_evt_reg.began;
    assign event_chan.vblank_fall = v_evt_reg.ended;
    assign event_chan.vblank_level = v_evt_reg.level;

    a_end_clears_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (h_evt_reg.ended || v_evt_reg.ended) |->
            !((h_evt_reg.ended && h_evt_reg.level) || (v_evt_reg.ended && v_evt_reg.level)))
        else $error("blanking level still set after end event");

    a_begin_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && h_evt_reg.began && !h_evt_reg.ended |-> h_evt_reg.level)
        else $error("horizontal begin without blanking level");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cycles_chan.ready)
        else $error("input stalled with empty result register");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_cycles_reg))
        else $error("input register lost while result stalled");

endmodule

`default_nettype wire

FILE: rtl/hbv_cfg_regs.sv
`default_nettype none

module hbv_cfg_regs
    import hbv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire hbv_reg_idx_t              cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    output hbv_cfg_t                       cfg
);

    hbv_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hblank_period <= HBLANK_PERIOD_RST;
            cfg_reg.hblank_duration <= HBLANK_DURATION_RST;
            cfg_reg.vblank_period <= VBLANK_PERIOD_RST;
            cfg_reg.vblank_duration <= VBLANK_DURATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HBLANK_PERIOD:   cfg_reg.hblank_period <= cfg_wdata[HB_CFG_WIDTH-1:0];
                REG_HBLANK_DURATION: cfg_reg.hblank_duration <= cfg_wdata[HB_CFG_WIDTH-1:0];
                REG_VBLANK_PERIOD:   cfg_reg.vblank_period <= cfg_wdata[VB_CFG_WIDTH-1:0];
                REG_VBLANK_DURATION: cfg_reg.vblank_duration <= cfg_wdata[VB_CFG_WIDTH-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/hbv_blank_gen.sv
`default_nettype none

module hbv_blank_gen
    import hbv_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int CFG_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [CYCLE_WIDTH-1:0] cycles,
    input  wire logic [CFG_WIDTH-1:0]   period,
    input  wire logic [CFG_WIDTH-1:0]   duration,
    output hbv_evt_t                    evt
);

    localparam int SW = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;
    localparam logic [SW-1:0] COUNT_MAX = SW'({COUNT_WIDTH{1'b1}});

    logic [COUNT_WIDTH-1:0] accum_reg;
    logic [COUNT_WIDTH-1:0] accum_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg;
    logic [COUNT_WIDTH-1:0] elapsed_next;
    logic                   flag_reg;
    logic                   flag_next;

    logic [SW-1:0] sum;
    logic [SW-1:0] sum_left;
    logic [SW-1:0] act;
    logic [SW-1:0] act_base;
    logic          began;
    logic          ended;
    logic          active;

    always_comb
    begin
        sum = SW'(accum_reg) + SW'(cycles);
        began = 1'b0;
        sum_left = sum;
        if (sum >= SW'(period))
        begin
            sum_left = sum - SW'(period);
            began = !flag_reg;
        end
        accum_next = (sum_left > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                            : sum_left[COUNT_WIDTH-1:0];

        active = flag_reg || began;
        act_base = began ? '0 : SW'(elapsed_reg);
        act = act_base + SW'(cycles);
        ended = 1'b0;
        flag_next = active;
        elapsed_next = began ? '0 : elapsed_reg;
        if (active)
        begin
            if (act >= SW'(duration))
            begin
                ended = 1'b1;
                flag_next = 1'b0;
                elapsed_next = '0;
            end
            else
            begin
                elapsed_next = (act > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                 : act[COUNT_WIDTH-1:0];
            end
        end

        evt.began = began;
        evt.ended = ended;
        evt.level = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            elapsed_reg <= '0;
            flag_reg <= 1'b0;
        end
        else if (step)
        begin
            accum_reg <= accum_next;
            elapsed_reg <= elapsed_next;
            flag_reg <= flag_next;
        end
    end

endmodule

`default_nettype wire

FILE: verif/hblank_vblank_event_generator_top_tb.sv
`default_nettype none

module hblank_vblank_event_generator_top_tb import hbv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_W = 16;
    localparam int FRAME_W = 24;
    localparam longint unsigned LINE_MASK = (64'd1 << LINE_W) - 1;
    localparam longint unsigned FRAME_MASK = (64'd1 << FRAME_W) - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 60;
    localparam int MAX_GAP = 13;
    localparam int SATURATE_STEPS = 80;

    typedef struct packed {
        logic hblank_rise;
        logic hblank_fall;
        logic vblank_rise;
        logic vblank_fall;
        logic hblank_level;
        logic vblank_level;
    } blank_events_t;

    typedef struct {
        longint unsigned accum;
        longint unsigned active;
        bit              flag;
    } blank_gen_t;

    typedef enum {
        CYC_UNIFORM,
        CYC_EDGES,
        CYC_MAX
    } cycle_style_t;

    class blanking_scoreboard;
        longint unsigned h_period;
        longint unsigned h_duration;
        longint unsigned v_period;
        longint unsigned v_duration;
        blank_gen_t      line_gen;
        blank_gen_t      frame_gen;
        blank_events_t   expected_events[$];
        int              errors;
        int              checked;
        int              h_starts;
        int              v_starts;

        function new();
            h_period = 64'(HBLANK_PERIOD_RST);
            h_duration = 64'(HBLANK_DURATION_RST);
            v_period = 64'(VBLANK_PERIOD_RST);
            v_duration = 64'(VBLANK_DURATION_RST);
            line_gen = '{0, 0, 1'b0};
            frame_gen = '{0, 0, 1'b0};
            errors = 0;
            checked = 0;
            h_starts = 0;
            v_starts = 0;
        endfunction

        function void write_reg(hbv_reg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_HBLANK_PERIOD:   h_period = 64'(data[HB_CFG_WIDTH-1:0]);
                REG_HBLANK_DURATION: h_duration = 64'(data[HB_CFG_WIDTH-1:0]);
                REG_VBLANK_PERIOD:   v_period = 64'(data[VB_CFG_WIDTH-1:0]);
                REG_VBLANK_DURATION: v_duration = 64'(data[VB_CFG_WIDTH-1:0]);
                default:             ;
            endcase
        endfunction

        function blank_gen_t advance(blank_gen_t g, longint unsigned cyc,
                                     longint unsigned period, longint unsigned duration,
                                     longint unsigned mask, output logic began,
                                     output logic ended);
            longint unsigned total;
            longint unsigned active;
            began = 1'b0;
            ended = 1'b0;
            total = g.accum + cyc;
            // one period at most per step
            if (total >= period) begin
                total = total - period;
                if (!g.flag) begin
                    g.flag = 1'b1;
                    g.active = 0;
                    began = 1'b1;
                end
            end
            g.accum = (total > mask) ? mask : total;
            if (g.flag) begin
                active = g.active + cyc;
                if (active >= duration) begin
                    g.flag = 1'b0;
                    g.active = 0;
                    ended = 1'b1;
                end
                else begin
                    g.active = (active > mask) ? mask : active;
                end
            end
            return g;
        endfunction

        function void note_cycles(logic [CYCLE_WIDTH-1:0] cyc);
            blank_events_t ev;
            logic hb, he, vb, ve;
            line_gen = advance(line_gen, 64'(cyc), h_period, h_duration, LINE_MASK, hb, he);
            frame_gen = advance(frame_gen, 64'(cyc), v_period, v_duration, FRAME_MASK,
                                vb, ve);
            ev = '{hb, he, vb, ve, line_gen.flag, frame_gen.flag};
            h_starts += int'(hb);
            v_starts += int'(vb);
            expected_events.push_back(ev);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_events(blank_events_t got);
            blank_events_t want;
            logic [5:0] want_bits;
            logic [5:0] got_bits;
            string names[6] = '{"hblank_rise", "hblank_fall", "vblank_rise",
                                "vblank_fall", "hblank_level", "vblank_level"};
            if (expected_events.size() == 0) begin
                report("event set arrived with no request pending");
                return;
            end
            want = expected_events.pop_front();
            want_bits = want;
            got_bits = got;
            checked++;
            for (int i = 0; i < 6; i++)
                if (got_bits[5-i] !== want_bits[5-i])
                    report($sformatf("event set %0d %s: got %b expected %b", checked,
                                     names[i], got_bits[5-i], want_bits[5-i]));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    hbv_reg_idx_t              cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

    int src_max_gap = MAX_GAP;
    int sink_max_gap = MAX_GAP;
    bit long_hold_armed = 1'b0;
    int settings_used = 1;

    logic [CYCLE_WIDTH-1:0] opening_steps [23] = '{
        10'd0, 10'd1023, 10'd1023, 10'd200, 10'd100, 10'd90, 10'd1, 10'd512,
        10'h155, 10'h2AA, 10'd1023, 10'd1023, 10'd1023, 10'd2, 10'd4, 10'd8,
        10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd0, 10'd1023
    };

    blanking_scoreboard sb = new();

    hbv_cycles_if cycles_if ();
    hbv_event_if  event_if ();

    hblank_vblank_event_generator_top #(
        .LINE_COUNT_WIDTH(LINE_W),
        .FRAME_COUNT_WIDTH(FRAME_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cycles_chan(cycles_if),
        .event_chan(event_if)
    );

    always #1 clk = ~clk;

    function automatic logic [CYCLE_WIDTH-1:0] pick_cycles(cycle_style_t style);
        case (style)
            CYC_MAX: return '1;
            CYC_EDGES:
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return CYCLE_WIDTH'($urandom_range(0, 15));
                    3:       return CYCLE_WIDTH'($urandom_range(1008, 1023));
                    default: return CYCLE_WIDTH'($urandom_range(0, 1023));
                endcase
            default: return CYCLE_WIDTH'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic send_cycles(logic [CYCLE_WIDTH-1:0] cyc);
        int gap;
        gap = int'($urandom_range(0, src_max_gap));
        if (gap > 0) begin
            cycles_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cycles_if.valid <= 1'b1;
        cycles_if.elapsed_cycles <= cyc;
        @(posedge clk);
        while (!cycles_if.ready) @(posedge clk);
        sb.note_cycles(cyc);
    endtask

    task automatic wait_for_drain();
        cycles_if.valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(hbv_reg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(logic [CFG_DATA_WIDTH-1:0] hp, logic [CFG_DATA_WIDTH-1:0] hd,
                                logic [CFG_DATA_WIDTH-1:0] vp, logic [CFG_DATA_WIDTH-1:0] vd);
        wait_for_drain();
        write_one(REG_HBLANK_PERIOD, hp);
        write_one(REG_HBLANK_DURATION, hd);
        write_one(REG_VBLANK_PERIOD, vp);
        write_one(REG_VBLANK_DURATION, vd);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(int count, cycle_style_t style, int src_gap, int sink_gap);
        src_max_gap = src_gap;
        sink_max_gap = sink_gap;
        repeat (count) send_cycles(pick_cycles(style));
    endtask

    always @(posedge clk)
        if (rst_n && event_if.valid && event_if.ready)
            sb.check_events(blank_events_t'{event_if.hblank_rise, event_if.hblank_fall,
                                            event_if.vblank_rise, event_if.vblank_fall,
                                            event_if.hblank_level, event_if.vblank_level});

    initial begin : result_sink
        int gap;
        event_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = int'($urandom_range(0, sink_max_gap));
            // long hold so requests back up and the input stalls
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                event_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            event_if.ready <= 1'b1;
            @(posedge clk);
            while (!event_if.valid) @(posedge clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((cycles_if.valid && cycles_if.ready) || (event_if.valid && event_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("** hblank_vblank_event_generator_top: FAILED **");
        $finish;
    end

    initial begin
        logic [CFG_DATA_WIDTH-1:0] hp, hd, vp, vd;
        rst_n <= 1'b0;
        cycles_if.valid <= 1'b0;
        cycles_if.elapsed_cycles <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_HBLANK_PERIOD;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        foreach (opening_steps[i])
            send_cycles(opening_steps[i]);

        program_regs(24'd1024, 24'd1, 24'd1024, 24'd1);
        run_phase(80, CYC_EDGES, MAX_GAP, MAX_GAP);

        // zero period and zero duration
        program_regs('0, '0, '0, '0);
        run_phase(15, CYC_EDGES, 0, 0);

        // periods shorter than one step
        program_regs(24'd5, 24'd3, 24'd700, 24'd2000);
        run_phase(60, CYC_UNIFORM, MAX_GAP, 0);

        // all ones, upper bits dropped on the line registers
        program_regs('1, '1, '1, '1);
        run_phase(100, CYC_MAX, 0, MAX_GAP);

        hp = CFG_DATA_WIDTH'($urandom_range(1024, 4000));
        hd = CFG_DATA_WIDTH'($urandom_range(1, hp));
        vp = CFG_DATA_WIDTH'($urandom_range(1024, 30000));
        vd = CFG_DATA_WIDTH'($urandom_range(1, vp));
        program_regs(hp, hd, vp, vd);
        long_hold_armed = 1'b1;
        run_phase(120, CYC_UNIFORM, 0, 0);

        program_regs(CFG_DATA_WIDTH'($urandom), CFG_DATA_WIDTH'($urandom),
                     CFG_DATA_WIDTH'($urandom), CFG_DATA_WIDTH'($urandom));
        run_phase(60, CYC_UNIFORM, MAX_GAP, MAX_GAP);

        repeat (2) begin
            hp = CFG_DATA_WIDTH'($urandom_range(1024, 3000));
            hd = CFG_DATA_WIDTH'($urandom_range(1, hp));
            vp = CFG_DATA_WIDTH'($urandom_range(1024, 12000));
            vd = CFG_DATA_WIDTH'($urandom_range(1, vp));
            program_regs(hp, hd, vp, vd);
            run_phase(40, CYC_EDGES, MAX_GAP, MAX_GAP);
        end

        // line accumulator runs up to all ones
        program_regs('0, 24'hFFFF, '0, '0);
        run_phase(SATURATE_STEPS, CYC_MAX, 0, 0);

        program_regs(HBLANK_PERIOD_RST, HBLANK_DURATION_RST, VBLANK_PERIOD_RST,
                     VBLANK_DURATION_RST);
        run_phase(40, CYC_UNIFORM, MAX_GAP, MAX_GAP);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d event sets over %0d register settings", sb.checked,
                 settings_used);
        $display("line blanking starts %0d, frame blanking starts %0d", sb.h_starts,
                 sb.v_starts);
        if (sb.errors == 0) begin
            $display("** hblank_vblank_event_generator_top: PASSED **");
        end
        else begin
            $display("%0d mismatches", sb.errors);
            $display("** hblank_vblank_event_generator_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: hblank_vblank_event_generator_top.f
rtl/hbv_pkg.sv
rtl/hbv_channels.sv
rtl/hbv_cfg_regs.sv
rtl/hbv_blank_gen.sv
rtl/hblank_vblank_event_generator_top.sv
verif/hblank_vblank_event_generator_top_tb.sv
